FILE: rtl/rsac_pkg.sv
// ----------------------------------------------------------------------------
// rsac_pkg
// Shared types, constants and helper functions for the rotated sprite
// alpha compositor.
// ----------------------------------------------------------------------------
package rsac_pkg;

    // Sprite store geometry
    localparam int MAX_SPRITE_W   = 512;
    localparam int MAX_SPRITE_H   = 64;
    localparam int MAX_SCREEN_DIM = 1024;
    localparam int COL_W          = $clog2(MAX_SPRITE_W);
    localparam int ROW_W          = $clog2(MAX_SPRITE_H);
    localparam int ADDR_W         = COL_W + ROW_W;
    localparam int SPRITE_DEPTH   = MAX_SPRITE_W * MAX_SPRITE_H;

    // Field widths
    localparam int PIX_W    = 32;
    localparam int XY_W     = 10;
    localparam int TRIG_W   = 16;
    localparam int WIDTH_W  = 10;
    localparam int HEIGHT_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Rotation arithmetic widths
    localparam int FXY_W   = XY_W + 1;
    localparam int PROD_W  = FXY_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_W  = 14;
    localparam int QUOT_W  = SUM_W - FRAC_W;
    localparam int COORD_W = 16;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_COMP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_COL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_ROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd7;

    // Configuration reset values
    localparam logic signed [TRIG_W-1:0] RST_COS_ANGLE   = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] RST_SIN_ANGLE   = 16'sd0;
    localparam logic [COL_W-1:0]         RST_PIVOT_COL   = COL_W'(202);
    localparam logic [ROW_W-1:0]         RST_PIVOT_ROW   = ROW_W'(30);
    localparam logic [XY_W-1:0]          RST_CENTER_X    = XY_W'(240);
    localparam logic [XY_W-1:0]          RST_CENTER_Y    = XY_W'(240);
    localparam logic [WIDTH_W-1:0]       RST_SPRITE_W    = WIDTH_W'(363);
    localparam logic [HEIGHT_W-1:0]      RST_SPRITE_H    = HEIGHT_W'(60);

    // Blend constants
    localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // One queue entry: a load or a classified composite
    typedef struct packed {
        logic              is_load;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } qent_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
        logic pop;
    } queue_stat_t;

    // Front status seen by the top level
    typedef struct packed {
        logic last_valid;
        logic push;
    } front_stat_t;

    // Exact x / 255 for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: rtl/rsac_if.sv
// ----------------------------------------------------------------------------
// rsac_if
// Valid/ready channel interfaces for the input items, the result items and
// the configuration write port.
// ----------------------------------------------------------------------------
interface rsac_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [rsac_pkg::COL_W-1:0]      load_col;
    logic [rsac_pkg::ROW_W-1:0]      load_row;
    logic [rsac_pkg::PIX_W-1:0]      load_word;
    logic [rsac_pkg::XY_W-1:0]       dest_x;
    logic [rsac_pkg::XY_W-1:0]       dest_y;
    logic [rsac_pkg::PIX_W-1:0]      dest_pixel;

    modport source (output valid, func, load_col, load_row, load_word,
                    dest_x, dest_y, dest_pixel, input ready);
    modport sink   (input valid, func, load_col, load_row, load_word,
                    dest_x, dest_y, dest_pixel, output ready);
endinterface

interface rsac_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsac_pkg::PIX_W-1:0] out_pixel;
    logic                       covered;

    modport source (output valid, out_pixel, covered, input ready);
    modport sink   (input valid, out_pixel, covered, output ready);
endinterface

interface rsac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rsac_pkg::CFG_IDX_W-1:0]  index;
    logic [rsac_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rsac_queue.sv
// ----------------------------------------------------------------------------
// rsac_queue
// Small FIFO that decouples the coordinate front end from the sprite
// store and blend back end.
// ----------------------------------------------------------------------------
module rsac_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rsac_pkg::qent_t       push_ent,
    input  logic                  pop,
    output rsac_pkg::qent_t       head_ent,
    output rsac_pkg::queue_stat_t stat
);

    rsac_pkg::qent_t                 ent_reg [rsac_pkg::QUEUE_DEPTH];
    logic [rsac_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rsac_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rsac_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    // Guard the pointers against misuse
    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    assign stat.full  = (cnt_reg == rsac_pkg::QCNT_W'(rsac_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign stat.pop   = do_pop;
    assign head_ent   = ent_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

FILE: rtl/rsac_front.sv
// ----------------------------------------------------------------------------
// rsac_front
// Configuration registers and the three-stage inverse rotation pipeline.
// Classifies each item as a load or a composite and pushes it to the queue.
// ----------------------------------------------------------------------------
module rsac_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    rsac_in_if.sink               in_ch,
    rsac_cfg_if.sink              cfg_ch,
    input  logic                  q_full,
    output logic                  push,
    output rsac_pkg::qent_t       push_ent,
    output rsac_pkg::front_stat_t stat
);

    // Configuration registers
    logic signed [rsac_pkg::TRIG_W-1:0]  cos_reg, sin_reg;
    logic [rsac_pkg::COL_W-1:0]          pivot_col_reg;
    logic [rsac_pkg::ROW_W-1:0]          pivot_row_reg;
    logic [rsac_pkg::XY_W-1:0]           center_x_reg, center_y_reg;
    logic [rsac_pkg::WIDTH_W-1:0]        spr_w_reg;
    logic [rsac_pkg::HEIGHT_W-1:0]       spr_h_reg;

    // Stage 1: offsets from the center
    logic                                s1_v_reg;
    logic                                s1_load_reg, s1_ok_reg;
    logic [rsac_pkg::ADDR_W-1:0]         s1_addr_reg;
    logic [rsac_pkg::PIX_W-1:0]          s1_pix_reg;
    logic signed [rsac_pkg::FXY_W-1:0]   s1_fx_reg, s1_fy_reg;
    logic signed [rsac_pkg::FXY_W-1:0]   fx_next, fy_next;
    logic                                onscr_next, load_ok_next;

    // Stage 2: products
    logic                                s2_v_reg;
    logic                                s2_load_reg, s2_ok_reg;
    logic [rsac_pkg::ADDR_W-1:0]         s2_addr_reg;
    logic [rsac_pkg::PIX_W-1:0]          s2_pix_reg;
    logic signed [rsac_pkg::PROD_W-1:0]  xc_reg, ys_reg, xs_reg, yc_reg;

    // Stage 3: rounded sums
    logic                                s3_v_reg;
    logic                                s3_load_reg, s3_ok_reg;
    logic [rsac_pkg::ADDR_W-1:0]         s3_addr_reg;
    logic [rsac_pkg::PIX_W-1:0]          s3_pix_reg;
    logic signed [rsac_pkg::SUM_W-1:0]   u_reg, v_reg;
    logic signed [rsac_pkg::SUM_W-1:0]   u_next, v_next;

    // Classification
    logic signed [rsac_pkg::SUM_W-1:0]   u_adj, v_adj;
    logic signed [rsac_pkg::COORD_W-1:0] col, row;
    logic [rsac_pkg::WIDTH_W-1:0]        w_lim;
    logic [rsac_pkg::HEIGHT_W-1:0]       h_lim;
    logic                                in_bounds;

    logic s1_ready, s2_ready, s3_ready;

    // Stage handshakes: a stage loads when empty or when it moves on
    assign s3_ready     = !s3_v_reg || !q_full;
    assign s2_ready     = !s2_v_reg || s3_ready;
    assign s1_ready     = !s1_v_reg || s2_ready;
    assign in_ch.ready  = s1_ready;
    assign cfg_ch.ready = 1'b1;
    assign push         = s3_v_reg && !q_full;
    assign stat.last_valid = s3_v_reg;
    assign stat.push       = push;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg       <= rsac_pkg::RST_COS_ANGLE;
            sin_reg       <= rsac_pkg::RST_SIN_ANGLE;
            pivot_col_reg <= rsac_pkg::RST_PIVOT_COL;
            pivot_row_reg <= rsac_pkg::RST_PIVOT_ROW;
            center_x_reg  <= rsac_pkg::RST_CENTER_X;
            center_y_reg  <= rsac_pkg::RST_CENTER_Y;
            spr_w_reg     <= rsac_pkg::RST_SPRITE_W;
            spr_h_reg     <= rsac_pkg::RST_SPRITE_H;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                rsac_pkg::REG_COS_ANGLE:     cos_reg       <= cfg_ch.data;
                rsac_pkg::REG_SIN_ANGLE:     sin_reg       <= cfg_ch.data;
                rsac_pkg::REG_PIVOT_COL:     pivot_col_reg <= cfg_ch.data[rsac_pkg::COL_W-1:0];
                rsac_pkg::REG_PIVOT_ROW:     pivot_row_reg <= cfg_ch.data[rsac_pkg::ROW_W-1:0];
                rsac_pkg::REG_CENTER_X:      center_x_reg  <= cfg_ch.data[rsac_pkg::XY_W-1:0];
                rsac_pkg::REG_CENTER_Y:      center_y_reg  <= cfg_ch.data[rsac_pkg::XY_W-1:0];
                rsac_pkg::REG_SPRITE_WIDTH:  spr_w_reg     <= cfg_ch.data[rsac_pkg::WIDTH_W-1:0];
                rsac_pkg::REG_SPRITE_HEIGHT: spr_h_reg     <= cfg_ch.data[rsac_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Offsets from the screen center, screen and load range checks
    always_comb
    begin
        fx_next = $signed({1'b0, in_ch.dest_x}) - $signed({1'b0, center_x_reg});
        fy_next = $signed({1'b0, in_ch.dest_y}) - $signed({1'b0, center_y_reg});
        onscr_next = ({1'b0, in_ch.dest_x} < (rsac_pkg::XY_W + 1)'(rsac_pkg::MAX_SCREEN_DIM))
                  && ({1'b0, in_ch.dest_y} < (rsac_pkg::XY_W + 1)'(rsac_pkg::MAX_SCREEN_DIM));
        load_ok_next = ({1'b0, in_ch.load_col} < (rsac_pkg::COL_W + 1)'(rsac_pkg::MAX_SPRITE_W))
                    && ({1'b0, in_ch.load_row} < (rsac_pkg::ROW_W + 1)'(rsac_pkg::MAX_SPRITE_H));
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_load_reg <= (in_ch.func == rsac_pkg::FUNC_LOAD);
            s1_ok_reg   <= (in_ch.func == rsac_pkg::FUNC_LOAD) ? load_ok_next : onscr_next;
            s1_addr_reg <= {in_ch.load_row, in_ch.load_col};
            s1_pix_reg  <= (in_ch.func == rsac_pkg::FUNC_LOAD) ? in_ch.load_word
                                                               : in_ch.dest_pixel;
            s1_fx_reg   <= fx_next;
            s1_fy_reg   <= fy_next;
        end
    end

    // Stage 2 payload: four rotation products
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_load_reg <= s1_load_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_pix_reg  <= s1_pix_reg;
            xc_reg      <= rsac_pkg::PROD_W'(s1_fx_reg) * rsac_pkg::PROD_W'(cos_reg);
            ys_reg      <= rsac_pkg::PROD_W'(s1_fy_reg) * rsac_pkg::PROD_W'(sin_reg);
            xs_reg      <= rsac_pkg::PROD_W'(s1_fx_reg) * rsac_pkg::PROD_W'(sin_reg);
            yc_reg      <= rsac_pkg::PROD_W'(s1_fy_reg) * rsac_pkg::PROD_W'(cos_reg);
        end
    end

    // Sum products and add the half
    always_comb
    begin
        u_next = rsac_pkg::SUM_W'(xc_reg) + rsac_pkg::SUM_W'(ys_reg)
               + $signed(rsac_pkg::SUM_W'(1 << (rsac_pkg::FRAC_W - 1)));
        v_next = rsac_pkg::SUM_W'(yc_reg) - rsac_pkg::SUM_W'(xs_reg)
               + $signed(rsac_pkg::SUM_W'(1 << (rsac_pkg::FRAC_W - 1)));
    end

    // Stage 3 payload
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_load_reg <= s2_load_reg;
            s3_ok_reg   <= s2_ok_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_pix_reg  <= s2_pix_reg;
            u_reg       <= u_next;
            v_reg       <= v_next;
        end
    end

    // Truncate toward zero, offset by the pivot and test sprite bounds
    always_comb
    begin
        u_adj = u_reg + (u_reg[rsac_pkg::SUM_W-1]
                ? $signed(rsac_pkg::SUM_W'((1 << rsac_pkg::FRAC_W) - 1))
                : $signed(rsac_pkg::SUM_W'(0)));
        v_adj = v_reg + (v_reg[rsac_pkg::SUM_W-1]
                ? $signed(rsac_pkg::SUM_W'((1 << rsac_pkg::FRAC_W) - 1))
                : $signed(rsac_pkg::SUM_W'(0)));
        col = $signed(rsac_pkg::COORD_W'(pivot_col_reg))
            + $signed(rsac_pkg::COORD_W'($signed(u_adj[rsac_pkg::SUM_W-1:rsac_pkg::FRAC_W])));
        row = $signed(rsac_pkg::COORD_W'(pivot_row_reg))
            + $signed(rsac_pkg::COORD_W'($signed(v_adj[rsac_pkg::SUM_W-1:rsac_pkg::FRAC_W])));
        w_lim = (spr_w_reg < rsac_pkg::WIDTH_W'(rsac_pkg::MAX_SPRITE_W))
              ? spr_w_reg : rsac_pkg::WIDTH_W'(rsac_pkg::MAX_SPRITE_W);
        h_lim = (spr_h_reg < rsac_pkg::HEIGHT_W'(rsac_pkg::MAX_SPRITE_H))
              ? spr_h_reg : rsac_pkg::HEIGHT_W'(rsac_pkg::MAX_SPRITE_H);
        in_bounds = !col[rsac_pkg::COORD_W-1] && !row[rsac_pkg::COORD_W-1]
                 && (col < $signed(rsac_pkg::COORD_W'(w_lim)))
                 && (row < $signed(rsac_pkg::COORD_W'(h_lim)));

        push_ent.is_load = s3_load_reg;
        push_ent.pix     = s3_pix_reg;
        if (s3_load_reg)
        begin
            push_ent.hit  = s3_ok_reg;
            push_ent.addr = s3_addr_reg;
        end
        else
        begin
            push_ent.hit  = s3_ok_reg && in_bounds;
            push_ent.addr = {row[rsac_pkg::ROW_W-1:0], col[rsac_pkg::COL_W-1:0]};
        end
    end

endmodule

FILE: rtl/rsac_back.sv
// ----------------------------------------------------------------------------
// rsac_back
// Sprite store, fetch and source-over blend. Pops queue entries in order,
// so every load lands before any later composite reads its word.
// ----------------------------------------------------------------------------
module rsac_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsac_pkg::qent_t       head_ent,
    input  logic                  q_empty,
    output logic                  pop,
    rsac_out_if.source            out_ch
);

    logic [rsac_pkg::PIX_W-1:0] sprite_mem [rsac_pkg::SPRITE_DEPTH];

    // Fetch stage
    logic                       b1_v_reg;
    logic                       b1_hit_reg;
    logic [rsac_pkg::PIX_W-1:0] b1_dpix_reg;
    logic [rsac_pkg::PIX_W-1:0] rd_word_reg;

    // Multiply stage
    logic                       b2_v_reg;
    logic                       b2_hit_reg, b2_opaque_reg;
    logic [rsac_pkg::PIX_W-1:0] b2_sword_reg, b2_dpix_reg;
    logic [15:0]                r_sum_reg, g_sum_reg, b_sum_reg;
    logic [7:0]                 alpha, inv_alpha;
    logic [15:0]                r_sum_next, g_sum_next, b_sum_next;

    // Output register
    logic                       o_v_reg;
    logic [rsac_pkg::PIX_W-1:0] o_pix_reg, o_pix_next;
    logic                       o_cov_reg;

    logic o_ready, b2_ready, b1_ready;

    // Stage handshakes
    assign o_ready  = !o_v_reg || out_ch.ready;
    assign b2_ready = !b2_v_reg || o_ready;
    assign b1_ready = !b1_v_reg || b2_ready;
    assign pop      = !q_empty && b1_ready;

    assign out_ch.valid     = o_v_reg;
    assign out_ch.out_pixel = o_pix_reg;
    assign out_ch.covered   = o_cov_reg;

    // Write loads and fetch composite words
    always_ff @(posedge clk)
    begin
        if (pop && head_ent.is_load && head_ent.hit)
        begin
            sprite_mem[head_ent.addr] <= head_ent.pix;
        end
        if (pop && !head_ent.is_load)
        begin
            rd_word_reg <= sprite_mem[head_ent.addr];
        end
    end

    // Valid bits; loads stop at the store and send nothing down the blend pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (b1_ready)
            begin
                b1_v_reg <= pop && !head_ent.is_load;
            end
            if (b2_ready)
            begin
                b2_v_reg <= b1_v_reg;
            end
            if (o_ready)
            begin
                o_v_reg <= b2_v_reg;
            end
        end
    end

    // Fetch stage payload
    always_ff @(posedge clk)
    begin
        if (b1_ready)
        begin
            b1_hit_reg  <= head_ent.hit;
            b1_dpix_reg <= head_ent.pix;
        end
    end

    // Weight source and destination channels
    always_comb
    begin
        alpha      = rd_word_reg[31:24];
        inv_alpha  = rsac_pkg::ALPHA_OPAQUE - alpha;
        r_sum_next = 16'(rd_word_reg[23:16]) * 16'(alpha)
                   + 16'(b1_dpix_reg[23:16]) * 16'(inv_alpha);
        g_sum_next = 16'(rd_word_reg[15:8]) * 16'(alpha)
                   + 16'(b1_dpix_reg[15:8]) * 16'(inv_alpha);
        b_sum_next = 16'(rd_word_reg[7:0]) * 16'(alpha)
                   + 16'(b1_dpix_reg[7:0]) * 16'(inv_alpha);
    end

    always_ff @(posedge clk)
    begin
        if (b2_ready)
        begin
            b2_hit_reg    <= b1_hit_reg && (alpha != rsac_pkg::ALPHA_CLEAR);
            b2_opaque_reg <= (alpha == rsac_pkg::ALPHA_OPAQUE);
            b2_sword_reg  <= rd_word_reg;
            b2_dpix_reg   <= b1_dpix_reg;
            r_sum_reg     <= r_sum_next;
            g_sum_reg     <= g_sum_next;
            b_sum_reg     <= b_sum_next;
        end
    end

    // Normalize and select the result pixel
    always_comb
    begin
        priority if (!b2_hit_reg)
        begin
            o_pix_next = b2_dpix_reg;
        end
        else if (b2_opaque_reg)
        begin
            o_pix_next = b2_sword_reg;
        end
        else
        begin
            o_pix_next = {rsac_pkg::ALPHA_OPAQUE, rsac_pkg::div255(r_sum_reg),
                          rsac_pkg::div255(g_sum_reg), rsac_pkg::div255(b_sum_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready)
        begin
            o_pix_reg <= o_pix_next;
            o_cov_reg <= b2_hit_reg;
        end
    end

endmodule

FILE: rtl/rotated_sprite_alpha_compositor.sv
// ----------------------------------------------------------------------------
// rotated_sprite_alpha_compositor
// Rotated ARGB8888 sprite blended source-over onto a stream of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries load items (func = 0) that write one sprite word at
//           (load_col, load_row), and composite items (func = 1) that carry
//           one destination pixel at (dest_x, dest_y).
//   out_ch  returns one out_pixel / covered pair per composite item, in
//           order; loads return nothing.
//   cfg_ch  writes the rotation, pivot, center and sprite size registers;
//           always ready, write only while the block is idle.
// Throughput is one item per clock while out_ch does not stall. A composite
// result passes through three front stages (center offset, rotation
// multipliers, rounding sums), one queue slot, the sprite store read and
// the blend multiply, then the output register.
// A four-entry queue sits between the rotation front end and the store;
// when out_ch stalls, the back end holds, the queue fills and only then
// does in_ch drop ready. Reset empties all pipelines and loads the
// register defaults; sprite store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module rotated_sprite_alpha_compositor
(
    input  logic       clk,
    input  logic       rst_n,
    rsac_in_if.sink    in_ch,
    rsac_cfg_if.sink   cfg_ch,
    rsac_out_if.source out_ch
);

    rsac_pkg::qent_t       push_ent, head_ent;
    rsac_pkg::queue_stat_t q_stat;
    rsac_pkg::front_stat_t f_stat;
    logic                  push, pop;

    // Rotation front end
    rsac_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg_ch   (cfg_ch),
        .q_full   (q_stat.full),
        .push     (push),
        .push_ent (push_ent),
        .stat     (f_stat)
    );

    // Decoupling queue
    rsac_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head_ent (head_ent),
        .stat     (q_stat)
    );

    // Store and blend back end
    rsac_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_ent (head_ent),
        .q_empty  (q_stat.empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("queue push while full");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("queue pop while empty");

    // Every pop the back end asks for is taken by the queue
    a_pop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.pop)
        else $error("queue ignored a pop request");

    // A finished front item moves on as soon as the queue has room
    a_front_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (f_stat.last_valid && !q_stat.full) |-> f_stat.push)
        else $error("front end held an item with queue space free");

endmodule

FILE: tb/rsac_tb_pkg.sv
// ----------------------------------------------------------------------------
// rsac_tb_pkg
// Register image and inverse-rotation lookup that the stimulus side and the
// result checker share, so both agree on which sprite word a pixel reads.
// ----------------------------------------------------------------------------
package rsac_tb_pkg;

    import rsac_pkg::*;

    // Host-visible registers as the block holds them
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q14;
        logic signed [TRIG_W-1:0] sin_q14;
        logic [COL_W-1:0]         pivot_col;
        logic [ROW_W-1:0]         pivot_row;
        logic [XY_W-1:0]          center_x;
        logic [XY_W-1:0]          center_y;
        logic [WIDTH_W-1:0]       width;
        logic [HEIGHT_W-1:0]      height;
    } rot_regs_t;

    function automatic rot_regs_t regs_after_reset();
        rot_regs_t r;
        r.cos_q14   = 16'sd16384;
        r.sin_q14   = 16'sd0;
        r.pivot_col = 9'd202;
        r.pivot_row = 6'd30;
        r.center_x  = 10'd240;
        r.center_y  = 10'd240;
        r.width     = 10'd363;
        r.height    = 7'd60;
        return r;
    endfunction

    // Apply one register write; bits above the register width are dropped
    function automatic rot_regs_t apply_reg_write(rot_regs_t r,
                                                  logic [CFG_IDX_W-1:0] idx,
                                                  logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_COS_ANGLE:     r.cos_q14   = data;
            REG_SIN_ANGLE:     r.sin_q14   = data;
            REG_PIVOT_COL:     r.pivot_col = data[COL_W-1:0];
            REG_PIVOT_ROW:     r.pivot_row = data[ROW_W-1:0];
            REG_CENTER_X:      r.center_x  = data[XY_W-1:0];
            REG_CENTER_Y:      r.center_y  = data[XY_W-1:0];
            REG_SPRITE_WIDTH:  r.width     = data[WIDTH_W-1:0];
            REG_SPRITE_HEIGHT: r.height    = data[HEIGHT_W-1:0];
            default: ;
        endcase
        return r;
    endfunction

    // Map a screen pixel back into the sprite; return 1 when it lands inside.
    // Rounding adds a half and then truncates toward zero, so negative
    // offsets round up at the half.
    function automatic bit locate_texel(rot_regs_t r, logic [XY_W-1:0] x,
                                        logic [XY_W-1:0] y,
                                        output logic [ADDR_W-1:0] addr);
        longint fx, fy, c, s, u, v, col, row, wlim, hlim;
        fx   = longint'(x) - longint'(r.center_x);
        fy   = longint'(y) - longint'(r.center_y);
        c    = longint'($signed(r.cos_q14));
        s    = longint'($signed(r.sin_q14));
        u    = fx * c + fy * s + 8192;
        v    = -fx * s + fy * c + 8192;
        col  = longint'(r.pivot_col) + u / 16384;
        row  = longint'(r.pivot_row) + v / 16384;
        wlim = (r.width < MAX_SPRITE_W) ? r.width : MAX_SPRITE_W;
        hlim = (r.height < MAX_SPRITE_H) ? r.height : MAX_SPRITE_H;
        addr = ADDR_W'(row * MAX_SPRITE_W + col);
        if (x >= MAX_SCREEN_DIM || y >= MAX_SCREEN_DIM)
            return 1'b0;
        return col >= 0 && col < wlim && row >= 0 && row < hlim;
    endfunction

endpackage

FILE: tb/sprite_blend_checker.sv
// ----------------------------------------------------------------------------
// sprite_blend_checker
// Watches the item, result and register channels, keeps its own sprite
// store and registers, works out each composite's pixel and coverage and
// compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module sprite_blend_checker
    import rsac_pkg::*;
    import rsac_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rsac_in_if   in_ch,
    rsac_cfg_if  cfg_ch,
    rsac_out_if  out_ch,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             covered;
    } blend_result_t;

    logic [PIX_W-1:0] sprite_mem [SPRITE_DEPTH];
    rot_regs_t        regs;
    blend_result_t    owed_q [$];
    blend_result_t    owed_head;
    int               fails = 0;

    // Source-over blend of the addressed sprite word onto the destination
    function automatic blend_result_t blend_pixel(logic [XY_W-1:0] x,
                                                  logic [XY_W-1:0] y,
                                                  logic [PIX_W-1:0] dpix);
        blend_result_t    r;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0] sp;
        int               a, s, d;
        r.pixel   = dpix;
        r.covered = 1'b0;
        if (!locate_texel(regs, x, y, addr))
            return r;
        sp = sprite_mem[addr];
        a  = sp[31:24];
        if (a == ALPHA_CLEAR)
            return r;
        r.covered = 1'b1;
        if (a == ALPHA_OPAQUE) begin
            r.pixel = sp;
        end
        else begin
            r.pixel[31:24] = ALPHA_OPAQUE;
            for (int ch = 0; ch < 3; ch++) begin
                s = sp[ch*8 +: 8];
                d = dpix[ch*8 +: 8];
                r.pixel[ch*8 +: 8] = 8'((s * a + d * (255 - a)) / 255);
            end
        end
        return r;
    endfunction

    // Track every transfer; compare results against the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs = regs_after_reset();
            owed_q.delete();
            pending    <= 0;
            fail_count <= fails;
        end
        else begin
            if (cfg_ch.valid && cfg_ch.ready)
                regs = apply_reg_write(regs, cfg_ch.index, cfg_ch.data);

            if (out_ch.valid && out_ch.ready) begin
                if (owed_q.size() == 0) begin
                    fails++;
                    $display("%0t ns: unrequested result, expected none, actual %08h/%0b",
                             $time, out_ch.out_pixel, out_ch.covered);
                end
                else begin
                    owed_head = owed_q.pop_front();
                    if (out_ch.out_pixel !== owed_head.pixel) begin
                        fails++;
                        $display("%0t ns: out_pixel mismatch, expected %08h, actual %08h",
                                 $time, owed_head.pixel, out_ch.out_pixel);
                    end
                    if (out_ch.covered !== owed_head.covered) begin
                        fails++;
                        $display("%0t ns: covered mismatch, expected %0b, actual %0b",
                                 $time, owed_head.covered, out_ch.covered);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.func == FUNC_LOAD)
                    sprite_mem[{in_ch.load_row, in_ch.load_col}] = in_ch.load_word;
                else
                    owed_q.push_back(blend_pixel(in_ch.dest_x, in_ch.dest_y,
                                                 in_ch.dest_pixel));
            end

            pending    <= owed_q.size();
            fail_count <= fails;
        end
    end

endmodule

FILE: tb/rotated_sprite_alpha_compositor_test.sv
// ----------------------------------------------------------------------------
// rotated_sprite_alpha_compositor_test
// Drives sprite loads and destination pixels into the compositor under a
// series of rotation, pivot, center and size settings, with random gaps on
// both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rotated_sprite_alpha_compositor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rsac_pkg::*;
    import rsac_tb_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 195;

    logic clk;
    logic rst_n;

    rsac_in_if  in_ch();
    rsac_cfg_if cfg_ch();
    rsac_out_if out_ch();

    int        fail_count;
    int        pending;
    bit        quiet = 1'b0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    rot_regs_t shadow;
    bit        loaded [SPRITE_DEPTH];

    rotated_sprite_alpha_compositor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    sprite_blend_checker blend_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_ch     (cfg_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result side now and then, except in quiet stretches
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // End the run when no channel has moved a transfer for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it
    task automatic push_item(input logic f, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [PIX_W-1:0] word,
                             input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic [PIX_W-1:0] pix);
        while (!quiet && $urandom_range(99) < 7)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= f;
        in_ch.load_col   <= col;
        in_ch.load_row   <= row;
        in_ch.load_word  <= word;
        in_ch.dest_x     <= x;
        in_ch.dest_y     <= y;
        in_ch.dest_pixel <= pix;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (f == FUNC_LOAD)
            loaded[{row, col}] = 1'b1;
        items_sent++;
    endtask

    task automatic load_word_at(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] word);
        push_item(FUNC_LOAD, addr[COL_W-1:0], addr[ADDR_W-1:COL_W], word,
                  XY_W'($urandom), XY_W'($urandom), $urandom);
    endtask

    // Sprite word spread over transparent, opaque, partial and arbitrary alpha
    function automatic logic [PIX_W-1:0] sprite_word();
        logic [23:0] rgb;
        rgb = 24'($urandom);
        case ($urandom_range(3))
            0: return {ALPHA_CLEAR, rgb};
            1: return {ALPHA_OPAQUE, rgb};
            2: return {8'($urandom_range(254, 1)), rgb};
            default: return $urandom;
        endcase
    endfunction

    // Composite one pixel; load its sprite word first when asked to, or when
    // the word it reads has never been written
    task automatic composite(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic [PIX_W-1:0] pix, input bit repaint,
                             input logic [PIX_W-1:0] word);
        logic [ADDR_W-1:0] addr;
        if (locate_texel(shadow, x, y, addr) && (repaint || !loaded[addr]))
            load_word_at(addr, repaint ? word : sprite_word());
        push_item(FUNC_COMP, COL_W'($urandom), ROW_W'($urandom), $urandom, x, y, pix);
    endtask

    // Drop valid and wait until every result is back and the block is quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, optionally with noise above its width
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value,
                           input int bits, input bit junk);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_DATA_W-1:0] mask;
        mask = CFG_DATA_W'((32'd1 << bits) - 1);
        data = CFG_DATA_W'(value) & mask;
        if (junk)
            data = data | (CFG_DATA_W'($urandom) & ~mask);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow = apply_reg_write(shadow, idx, data);
    endtask

    task automatic reprogram(input int cos_v, input int sin_v, input int pcol,
                             input int prow, input int cx, input int cy,
                             input int w, input int h, input bit junk);
        settle();
        set_reg(REG_COS_ANGLE, cos_v, TRIG_W, junk);
        set_reg(REG_SIN_ANGLE, sin_v, TRIG_W, junk);
        set_reg(REG_PIVOT_COL, pcol, COL_W, junk);
        set_reg(REG_PIVOT_ROW, prow, ROW_W, junk);
        set_reg(REG_CENTER_X, cx, XY_W, junk);
        set_reg(REG_CENTER_Y, cy, XY_W, junk);
        set_reg(REG_SPRITE_WIDTH, w, WIDTH_W, junk);
        set_reg(REG_SPRITE_HEIGHT, h, HEIGHT_W, junk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Pick a screen pixel, mostly one that lands on a chosen sprite texel
    task automatic aim_pixel(output logic [XY_W-1:0] x, output logic [XY_W-1:0] y);
        int  wlim, hlim, du, dv, px, py, ci, si, jx, jy;
        real c, s, det, fx, fy;
        wlim = (shadow.width < MAX_SPRITE_W) ? shadow.width : MAX_SPRITE_W;
        hlim = (shadow.height < MAX_SPRITE_H) ? shadow.height : MAX_SPRITE_H;
        ci   = $signed(shadow.cos_q14);
        si   = $signed(shadow.sin_q14);
        c    = ci;
        s    = si;
        det  = c * c + s * s;
        px   = $urandom_range(MAX_SCREEN_DIM - 1);
        py   = $urandom_range(MAX_SCREEN_DIM - 1);
        if ($urandom_range(99) < 80 && wlim > 0 && hlim > 0 && det > 0.0)
        begin
            du = $urandom_range(wlim - 1);
            dv = $urandom_range(hlim - 1);
            du = du - int'(shadow.pivot_col);
            dv = dv - int'(shadow.pivot_row);
            jx = $urandom_range(2);
            jy = $urandom_range(2);
            fx = 16384.0 * (c * du - s * dv) / det;
            fy = 16384.0 * (s * du + c * dv) / det;
            px = int'(shadow.center_x) + $rtoi(fx) + jx - 1;
            py = int'(shadow.center_y) + $rtoi(fy) + jy - 1;
            if (px < 0 || px >= MAX_SCREEN_DIM)
                px = $urandom_range(MAX_SCREEN_DIM - 1);
            if (py < 0 || py >= MAX_SCREEN_DIM)
                py = $urandom_range(MAX_SCREEN_DIM - 1);
        end
        x = XY_W'(px);
        y = XY_W'(py);
    endtask

    // Mostly load-then-read pairs and aimed reads, plus stray loads and reads
    task automatic random_phase(input int count);
        int               stop, pick;
        logic [XY_W-1:0]  x, y;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            pick = $urandom_range(99);
            aim_pixel(x, y);
            if (pick < 45)
                composite(x, y, $urandom, 1'b1, sprite_word());
            else if (pick < 80)
                composite(x, y, $urandom, 1'b0, '0);
            else if (pick < 90)
                load_word_at(ADDR_W'($urandom), sprite_word());
            else
                composite(XY_W'($urandom), XY_W'($urandom), $urandom, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_LOAD;
        in_ch.load_col   <= '0;
        in_ch.load_row   <= '0;
        in_ch.load_word  <= '0;
        in_ch.dest_x     <= '0;
        in_ch.dest_y     <= '0;
        in_ch.dest_pixel <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_COS_ANGLE;
        cfg_ch.data      <= '0;
        shadow = regs_after_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass under the reset registers: identity rotation
        load_word_at('0, 32'h0000_0000);
        load_word_at('1, 32'hFFFF_FFFF);
        composite(10'd240, 10'd240, 32'h89AB_CDEF, 1'b1, 32'hFF12_3456);
        composite(10'd241, 10'd240, 32'hCAFE_F00D, 1'b1, 32'h00AB_CDEF);
        composite(10'd239, 10'd241, 32'h00FF_00FF, 1'b1, 32'h80FF_00FF);
        composite(10'd200, 10'd250, 32'h0000_0000, 1'b1, 32'h01FF_FFFF);
        composite(10'd300, 10'd230, 32'hFF00_0000, 1'b1, 32'hFEFF_FFFF);
        composite(10'd240, 10'd240, 32'h1234_5678, 1'b0, '0);
        composite(10'd0, 10'd0, 32'hFFFF_FFFF, 1'b0, '0);
        composite(10'd1023, 10'd1023, 32'h0000_0000, 1'b0, '0);
        // last column and row, then one past each
        composite(10'd400, 10'd269, $urandom, 1'b1, 32'hFF00_FF00);
        composite(10'd401, 10'd240, $urandom, 1'b0, '0);
        composite(10'd240, 10'd270, $urandom, 1'b0, '0);
        // negative halves round toward zero onto column 0 and row 0
        composite(10'd37, 10'd240, $urandom, 1'b1, 32'h7F10_2030);
        composite(10'd36, 10'd240, $urandom, 1'b0, '0);
        composite(10'd240, 10'd209, $urandom, 1'b1, 32'hC0A0_B0C0);
        composite(10'd240, 10'd208, $urandom, 1'b0, '0);

        // Zero width, then zero height: nothing is covered
        reprogram(16384, 0, 202, 30, 240, 240, 0, 60, 1'b0);
        repeat (3) composite(10'd240, 10'd240, $urandom, 1'b0, '0);
        reprogram(16384, 0, 202, 30, 240, 240, 512, 0, 1'b0);
        repeat (3) composite(10'd240, 10'd240, $urandom, 1'b0, '0);

        // Half turn about the far corner, full-size sprite
        reprogram(-16384, 0, 0, 0, 1023, 1023, 512, 64, 1'b0);
        random_phase(PHASE_ITEMS);

        // Quarter turn with oversized limits; no idling on either side
        quiet = 1'b1;
        reprogram(0, -16384, 511, 0, 0, 0, 1023, 127, 1'b0);
        random_phase(PHASE_ITEMS);
        quiet = 1'b0;

        // Unsaturated extremes of both trig registers
        reprogram(32767, -32768, 511, 63, $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(127), 1'b1);
        random_phase(PHASE_ITEMS);

        // Single-texel sprite at an arbitrary angle
        reprogram(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                  $urandom_range(511), $urandom_range(63), $urandom_range(1023),
                  $urandom_range(1023), 1, 1, 1'b1);
        random_phase(PHASE_ITEMS);

        // Fully random settings, any 16-bit trig value
        reprogram($urandom_range(65535), $urandom_range(65535), $urandom_range(511),
                  $urandom_range(63), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(127), 1'b1);
        random_phase(PHASE_ITEMS);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
